/* src/idrc_pkg.sv */
// shared constants, types and lane helpers for the ipv4 destination rewrite block
package idrc_pkg;

    localparam int HOLD_WORDS = 10;
    localparam int IDX_W      = $clog2(HOLD_WORDS);
    localparam int CNT_W      = $clog2(HOLD_WORDS + 1);
    localparam int POS_W      = 7;
    localparam int BC_W       = 7;
    localparam int SUM_W      = 21;

    localparam logic [BC_W-1:0]  MIN_FRAME = 7'd46;
    localparam logic [BC_W-1:0]  BYTE_CAP  = 7'd80;
    localparam logic [15:0]      ETH_VLAN  = 16'h8100;
    localparam logic [15:0]      ETH_IPV4  = 16'h0800;
    localparam logic [POS_W-1:0] OFF_UNTAG = 7'd14;
    localparam logic [POS_W-1:0] OFF_TAG   = 7'd18;
    localparam logic [POS_W-1:0] CSUM_OFF  = 7'd10;
    localparam logic [POS_W-1:0] DHI_OFF   = 7'd16;
    localparam logic [POS_W-1:0] DLO_OFF   = 7'd18;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        LANE_KEEP,
        LANE_CSUM,
        LANE_DHI,
        LANE_DLO
    } t_lane;

    typedef struct packed {
        logic [63:0]      data;
        logic [3:0]       bytes;
        logic             last;
        t_lane [3:0]      lanes;
        logic [SUM_W-1:0] sum;
    } t_qent;

    typedef struct packed {
        logic  push;
        t_qent ent;
    } t_q_wr;

    // which patch, if any, lands on the 16-bit lane at byte position pos
    function automatic t_lane lane_code(input logic [POS_W-1:0] pos,
                                        input logic vlan, input logic ipv4);
        logic [POS_W-1:0] off;
        off = vlan ? OFF_TAG : OFF_UNTAG;
        lane_code = LANE_KEEP;
        if (ipv4) begin
            if (pos == off + CSUM_OFF) lane_code = LANE_CSUM;
            else if (pos == off + DHI_OFF) lane_code = LANE_DHI;
            else if (pos == off + DLO_OFF) lane_code = LANE_DLO;
        end
    endfunction

endpackage

/* src/idrc_fifo.sv */
// short queue between the front and back parts
module idrc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  idrc_pkg::t_q_wr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output idrc_pkg::t_qent o_ent,
    output logic           o_empty
);

    idrc_pkg::t_qent                   r_mem [idrc_pkg::Q_DEPTH];
    logic [idrc_pkg::Q_PTR_W-1:0]      r_wr, n_wr, r_rd, n_rd;
    logic [idrc_pkg::Q_CNT_W-1:0]      r_cnt, n_cnt;
    logic                              do_wr, do_rd;

    assign o_full  = (r_cnt == idrc_pkg::Q_CNT_W'(idrc_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr.push && !o_full;
    assign do_rd   = i_pop && !o_empty;
    assign o_ent   = r_mem[r_rd];

    always_comb begin
        n_wr  = do_wr ? r_wr + 1'b1 : r_wr;
        n_rd  = do_rd ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_wr && !do_rd) n_cnt = r_cnt + 1'b1;
        else if (!do_wr && do_rd) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr] <= i_wr.ent;
    end

endmodule

/* src/idrc_front.sv */
// front part: accepts words, holds the frame head, classifies and sums the header
module idrc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [63:0]      i_data,
    input  logic [3:0]       i_bytes,
    input  logic             i_last,
    input  logic [31:0]      i_dest,
    output idrc_pkg::t_q_wr  o_q_wr,
    input  logic             i_q_full
);

    localparam logic [1:0] ST_HOLD  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_PASS  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [63:0]                         r_held [idrc_pkg::HOLD_WORDS];
    logic [idrc_pkg::CNT_W-1:0]          r_held_cnt, n_held_cnt;
    logic [idrc_pkg::BC_W-1:0]           r_bc, n_bc;
    logic                                r_tagged, n_tagged;
    logic                                r_ipv4, n_ipv4;
    logic [5:0]                          r_hb, n_hb;
    logic [idrc_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [idrc_pkg::SUM_W-1:0]          r_sum, n_sum;
    logic                                r_done, n_done;
    logic [3:0]                          r_last_bytes, n_last_bytes;

    logic [3:0]                          eff;
    logic [63:0]                         d_mask;
    logic                                accept;
    logic [idrc_pkg::BC_W:0]             bc_sum;
    logic [idrc_pkg::BC_W-1:0]           new_bc;
    logic [15:0]                         type0, type1;
    logic                                c_tagged, c_ipv4;
    logic [5:0]                          c_hb;
    logic [idrc_pkg::POS_W-1:0]          c_need, need_eff;
    logic                                drop, release_now;
    logic                                idx_end;
    logic [idrc_pkg::POS_W-1:0]          off_r, hdr_end;
    logic [63:0]                         cur_word;
    logic [idrc_pkg::POS_W-1:0]          pos [4];
    idrc_pkg::t_lane [3:0]               codes;
    logic [idrc_pkg::SUM_W-1:0]          sweep_add;
    logic [15:0]                         lane_val;

    // byte masking of the short final word
    always_comb begin
        eff = 4'd8;
        if (i_last && (i_bytes inside {[4'd1:4'd8]})) eff = i_bytes;
        for (int b = 0; b < 8; b++) begin
            d_mask[63-8*b -: 8] = (4'(b) < eff) ? i_data[63-8*b -: 8] : 8'h00;
        end
    end

    assign o_full = (r_state == ST_SWEEP) || (r_state == ST_FLUSH) ||
                    ((r_state == ST_PASS) && i_q_full);
    assign accept = i_push && !o_full;

    // byte count with saturation
    assign bc_sum = {1'b0, r_bc} + (idrc_pkg::BC_W + 1)'(eff);
    assign new_bc = (bc_sum > {1'b0, idrc_pkg::BYTE_CAP}) ? idrc_pkg::BYTE_CAP
                                                         : bc_sum[idrc_pkg::BC_W-1:0];

    // classification from bytes 12..18, always in words one and two here
    assign type0    = r_held[1][31:16];
    assign type1    = r_held[2][63:48];
    assign c_tagged = (type0 == idrc_pkg::ETH_VLAN);
    assign c_ipv4   = c_tagged ? (type1 == idrc_pkg::ETH_IPV4) : (type0 == idrc_pkg::ETH_IPV4);
    assign c_hb     = {(c_tagged ? r_held[2][43:40] : r_held[1][11:8]), 2'b00};
    assign c_need   = (c_tagged ? idrc_pkg::OFF_TAG : idrc_pkg::OFF_UNTAG) +
                      idrc_pkg::POS_W'(c_hb);
    assign need_eff = (c_ipv4 && (c_need > idrc_pkg::MIN_FRAME)) ? c_need : idrc_pkg::MIN_FRAME;

    assign drop        = i_last && (new_bc < idrc_pkg::MIN_FRAME);
    assign release_now = (new_bc >= need_eff) || (i_last && !drop);

    assign idx_end = ((idrc_pkg::CNT_W'(r_idx) + 1'b1) == r_held_cnt);

    // per-lane patch codes and header sum contribution of the current held word
    assign off_r    = r_tagged ? idrc_pkg::OFF_TAG : idrc_pkg::OFF_UNTAG;
    assign hdr_end  = off_r + idrc_pkg::POS_W'(r_hb);
    assign cur_word = r_held[r_idx];

    always_comb begin
        sweep_add = '0;
        lane_val  = '0;
        for (int l = 0; l < 4; l++) begin
            pos[l]   = idrc_pkg::POS_W'({r_idx, 2'(l), 1'b0});
            codes[l] = idrc_pkg::lane_code(pos[l], r_tagged, r_ipv4);
            case (codes[l])
                idrc_pkg::LANE_CSUM: lane_val = 16'h0000;
                idrc_pkg::LANE_DHI:  lane_val = i_dest[31:16];
                idrc_pkg::LANE_DLO:  lane_val = i_dest[15:0];
                default:             lane_val = cur_word[63-16*l -: 16];
            endcase
            if (r_ipv4 && (pos[l] >= off_r) && (pos[l] < hdr_end))
                sweep_add = sweep_add + idrc_pkg::SUM_W'(lane_val);
        end
    end

    // queue write: flushed head words, then pass-through words
    always_comb begin
        o_q_wr.push      = 1'b0;
        o_q_wr.ent.data  = d_mask;
        o_q_wr.ent.bytes = eff;
        o_q_wr.ent.last  = i_last;
        o_q_wr.ent.lanes = '{default: idrc_pkg::LANE_KEEP};
        o_q_wr.ent.sum   = r_sum;
        if (r_state == ST_FLUSH) begin
            o_q_wr.push      = !i_q_full;
            o_q_wr.ent.data  = cur_word;
            o_q_wr.ent.bytes = (r_done && idx_end) ? r_last_bytes : 4'd8;
            o_q_wr.ent.last  = r_done && idx_end;
            o_q_wr.ent.lanes = codes;
        end else if (r_state == ST_PASS) begin
            o_q_wr.push = accept;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_held_cnt   = r_held_cnt;
        n_bc         = r_bc;
        n_tagged     = r_tagged;
        n_ipv4       = r_ipv4;
        n_hb         = r_hb;
        n_idx        = r_idx;
        n_sum        = r_sum;
        n_done       = r_done;
        n_last_bytes = r_last_bytes;
        case (r_state)
            ST_HOLD: begin
                if (accept) begin
                    if (drop) begin
                        n_held_cnt = '0;
                        n_bc       = '0;
                    end else begin
                        n_held_cnt = r_held_cnt + 1'b1;
                        n_bc       = new_bc;
                        if (release_now) begin
                            n_tagged     = c_tagged;
                            n_ipv4       = c_ipv4;
                            n_hb         = c_hb;
                            n_done       = i_last;
                            n_last_bytes = eff;
                            n_idx        = '0;
                            n_sum        = '0;
                            n_state      = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                n_sum = r_sum + sweep_add;
                if (idx_end) begin
                    n_idx   = '0;
                    n_state = ST_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!i_q_full) begin
                    if (idx_end) begin
                        n_idx = '0;
                        if (r_done) begin
                            n_held_cnt = '0;
                            n_bc       = '0;
                            n_state    = ST_HOLD;
                        end else begin
                            n_state = ST_PASS;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_PASS: begin
                if (accept && i_last) begin
                    n_held_cnt = '0;
                    n_bc       = '0;
                    n_state    = ST_HOLD;
                end
            end
            default: n_state = ST_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_HOLD;
            r_held_cnt   <= '0;
            r_bc         <= '0;
            r_tagged     <= 1'b0;
            r_ipv4       <= 1'b0;
            r_hb         <= '0;
            r_idx        <= '0;
            r_sum        <= '0;
            r_done       <= 1'b0;
            r_last_bytes <= '0;
        end else begin
            r_state      <= n_state;
            r_held_cnt   <= n_held_cnt;
            r_bc         <= n_bc;
            r_tagged     <= n_tagged;
            r_ipv4       <= n_ipv4;
            r_hb         <= n_hb;
            r_idx        <= n_idx;
            r_sum        <= n_sum;
            r_done       <= n_done;
            r_last_bytes <= n_last_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_HOLD) && accept && !drop)
            r_held[r_held_cnt[idrc_pkg::IDX_W-1:0]] <= d_mask;
    end

endmodule

/* src/idrc_back.sv */
// back part: folds the header sum, patches address and checksum lanes, output register
module idrc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  idrc_pkg::t_qent  i_ent,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic [31:0]      i_dest,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [63:0]      o_data,
    output logic [3:0]       o_bytes,
    output logic             o_last
);

    logic              r_valid;
    logic [63:0]       r_data, n_data;
    logic [3:0]        r_bytes;
    logic              r_last;
    logic              load;
    logic [16:0]       fold1;
    logic [16:0]       fold2;
    logic [15:0]       csum;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;
    assign o_empty = !r_valid;
    assign o_data  = r_data;
    assign o_bytes = r_bytes;
    assign o_last  = r_last;

    // ones-complement fold, two rounds cover the whole sum width
    assign fold1 = 17'(i_ent.sum[15:0]) + 17'(i_ent.sum[idrc_pkg::SUM_W-1:16]);
    assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    assign csum  = ~fold2[15:0];

    always_comb begin
        n_data = i_ent.data;
        for (int l = 0; l < 4; l++) begin
            case (i_ent.lanes[l])
                idrc_pkg::LANE_CSUM: n_data[63-16*l -: 16] = csum;
                idrc_pkg::LANE_DHI:  n_data[63-16*l -: 16] = i_dest[31:16];
                idrc_pkg::LANE_DLO:  n_data[63-16*l -: 16] = i_dest[15:0];
                default:             n_data[63-16*l -: 16] = i_ent.data[63-16*l -: 16];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data  <= n_data;
            r_bytes <= i_ent.bytes;
            r_last  <= i_ent.last;
        end
    end

endmodule

/* src/ipv4_dest_rewrite_checksum.sv */
// top level: ipv4 destination address rewrite with header checksum regeneration
// head: held until 46 bytes and the whole ipv4 header are in, then the held words (6 to
//   10) are summed one at a time and flushed into the queue; no new word is taken meanwhile
// throughput: one word per cycle outside the frame head while the queue is not full; the
//   head is handled by the single sum unit and the one-word flush path
// reset: i_rst_n synchronous, active low; clears frame tracking, queue, output stage, dest
module ipv4_dest_rewrite_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_in_data,
    input  logic [3:0]  i_in_bytes,
    input  logic        i_in_last,
    // result word channel
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_bytes,
    output logic        o_out_last,
    // destination address register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // replacement destination address, first octet in the top bits
    logic [31:0]      r_new_dest_ip;

    idrc_pkg::t_q_wr  q_wr;
    idrc_pkg::t_qent  q_head;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    // register writes are always taken; ready is tied high
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_dest_ip <= '0;
        end else if (i_cfg_valid) begin
            r_new_dest_ip <= i_cfg_data;
        end
    end

    // front: holds the frame head, decides release, sums the header,
    // then flushes held words and passes later words into the queue
    idrc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_data   (i_in_data),
        .i_bytes  (i_in_bytes),
        .i_last   (i_in_last),
        .i_dest   (r_new_dest_ip),
        .o_q_wr   (q_wr),
        .i_q_full (q_full)
    );

    // short queue that absorbs result-side stalls until it fills; the front waits when it is full
    idrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_ent   (q_head),
        .o_empty (q_empty)
    );

    // back: fold the sum into the checksum, patch lanes, hold the result
    // in an output register until it is popped
    idrc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ent     (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_dest    (r_new_dest_ip),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (o_out_data),
        .o_bytes   (o_out_bytes),
        .o_last    (o_out_last)
    );

endmodule

/* tb/idrc_tb_pkg.sv */
// frame word type and the scoreboard that predicts rewritten frames
package idrc_tb_pkg;

    localparam int unsigned HELD_MAX       = 10;
    localparam int unsigned MIN_BYTES      = 46;
    localparam int unsigned COUNT_CAP      = 80;
    localparam int unsigned REPORT_MAX     = 10;
    localparam int unsigned IP_AT_UNTAGGED = 14;
    localparam int unsigned IP_AT_TAGGED   = 18;
    localparam int unsigned CSUM_AT        = 10;
    localparam int unsigned DEST_AT        = 16;
    localparam logic [15:0] TPID_VLAN      = 16'h8100;
    localparam logic [15:0] TYPE_IPV4      = 16'h0800;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } t_frame_word;

    class rewrite_scoreboard;
        logic [31:0]  dest_ip;
        logic [63:0]  held[HELD_MAX];
        int unsigned  held_cnt;
        int unsigned  byte_cnt;
        int unsigned  hdr_len;
        bit           vlan;
        bit           ipv4;
        bit           passing;
        t_frame_word  expected_words[$];
        int unsigned  mismatch_count;

        function new();
            dest_ip        = '0;
            mismatch_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            held_cnt = 0;
            byte_cnt = 0;
            hdr_len  = 0;
            vlan     = 1'b0;
            ipv4     = 1'b0;
            passing  = 1'b0;
        endfunction

        // bytes beyond what has arrived read as zero
        function logic [7:0] head_byte(int unsigned pos);
            if (pos >= byte_cnt || (pos >> 3) >= held_cnt) return 8'h00;
            return held[pos >> 3][63 - 8 * (pos & 7) -: 8];
        endfunction

        function void patch_byte(int unsigned pos, logic [7:0] v);
            if (pos >= byte_cnt || (pos >> 3) >= held_cnt) return;
            held[pos >> 3][63 - 8 * (pos & 7) -: 8] = v;
        endfunction

        function int unsigned ip_at();
            return vlan ? IP_AT_TAGGED : IP_AT_UNTAGGED;
        endfunction

        function void regen_header();
            int unsigned off;
            int unsigned i;
            logic [31:0] s;
            off = ip_at();
            patch_byte(off + DEST_AT,     dest_ip[31:24]);
            patch_byte(off + DEST_AT + 1, dest_ip[23:16]);
            patch_byte(off + DEST_AT + 2, dest_ip[15:8]);
            patch_byte(off + DEST_AT + 3, dest_ip[7:0]);
            patch_byte(off + CSUM_AT,     8'h00);
            patch_byte(off + CSUM_AT + 1, 8'h00);
            s = '0;
            for (i = 0; i < hdr_len; i += 2)
                s += {16'h0000, head_byte(off + i), head_byte(off + i + 1)};
            while (s[31:16] != 16'h0000)
                s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
            s = ~s;
            patch_byte(off + CSUM_AT,     s[15:8]);
            patch_byte(off + CSUM_AT + 1, s[7:0]);
        endfunction

        function void accept_word(logic [63:0] data, logic [3:0] nbytes, logic last);
            logic [63:0] d;
            logic [7:0]  hb;
            int unsigned eff;
            int unsigned need;
            int unsigned off;
            int unsigned k;
            t_frame_word w;
            d   = data;
            eff = 8;
            if (last && nbytes >= 1 && nbytes <= 8) eff = nbytes;
            if (eff < 8) d = d & ({64{1'b1}} << (64 - 8 * eff));
            if (passing) begin
                w.data   = d;
                w.nbytes = 4'(eff);
                w.last   = last;
                expected_words.push_back(w);
                if (last) clear_frame();
                return;
            end
            if (held_cnt < HELD_MAX) begin
                held[held_cnt] = d;
                held_cnt++;
            end
            byte_cnt = byte_cnt + eff;
            if (byte_cnt > COUNT_CAP) byte_cnt = COUNT_CAP;
            if (byte_cnt < MIN_BYTES) begin
                if (last) clear_frame();
                return;
            end
            vlan    = {head_byte(12), head_byte(13)} == TPID_VLAN;
            off     = ip_at();
            ipv4    = {head_byte(off - 2), head_byte(off - 1)} == TYPE_IPV4;
            hb      = head_byte(off);
            hdr_len = 4 * hb[3:0];
            need    = ipv4 ? off + hdr_len : 0;
            if (need < MIN_BYTES) need = MIN_BYTES;
            if (!last && byte_cnt < need) return;
            if (ipv4) regen_header();
            for (k = 0; k < held_cnt; k++) begin
                w.data   = held[k];
                w.last   = last && (k + 1 == held_cnt);
                w.nbytes = w.last ? 4'(eff) : 4'd8;
                expected_words.push_back(w);
            end
            if (last) clear_frame();
            else passing = 1'b1;
        endfunction

        function void note_failure(string msg);
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) $display("%s", msg);
        endfunction

        function void check_word(logic [63:0] data, logic [3:0] nbytes, logic last);
            t_frame_word want;
            if (expected_words.size() == 0) begin
                note_failure($sformatf("unexpected output word: data %h bytes %0d last %0b",
                                       data, nbytes, last));
                return;
            end
            want = expected_words.pop_front();
            if (want.data !== data || want.nbytes !== nbytes || want.last !== last)
                note_failure($sformatf({"output word mismatch: expected data %h bytes %0d ",
                                        "last %0b, got data %h bytes %0d last %0b"},
                                       want.data, want.nbytes, want.last,
                                       data, nbytes, last));
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
// top-level testbench for the ipv4 destination rewrite and checksum block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // how the payload bytes of a built frame are filled
    typedef enum int unsigned {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZERO
    } t_fill;

    // idle percentages per phase: none, sender only, receiver only, both lightly
    localparam int unsigned SEND_IDLE[4]   = '{0, 65, 0, 6};
    localparam int unsigned POP_STALL[4]   = '{0, 0, 65, 6};
    localparam int unsigned PHASE_WORDS    = 106;
    localparam int unsigned SETTLE_CYCLES  = 64;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [63:0] i_in_data   = '0;
    logic [3:0]  i_in_bytes  = '0;
    logic        i_in_last   = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [63:0] o_out_data;
    logic [3:0]  o_out_bytes;
    logic        o_out_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = '0;

    idrc_tb_pkg::rewrite_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned words_sent    = 0;
    logic [7:0]  frame_bytes[$];

    ipv4_dest_rewrite_checksum dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_data   (i_in_data),
        .i_in_bytes  (i_in_bytes),
        .i_in_last   (i_in_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_data  (o_out_data),
        .o_out_bytes (o_out_bytes),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver: pop is redrawn every cycle; a zero stall percentage keeps it high
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // both monitors sample at the edge, before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.accept_word(i_in_data, i_in_bytes, i_in_last);
        if (i_rst_n && pop && !empty)
            sb.check_word(o_out_data, o_out_bytes, o_out_last);
    end

    // step the clock, then wait until every predicted word has been popped
    task automatic wait_results();
        do @(posedge i_clk); while (sb.expected_words.size() != 0);
    endtask

    // drop push, drain, then give a dropped runt frame time to clear the block
    task automatic settle();
        push <= 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // destination register write; the block is idle whenever this is called
    task automatic write_dest(input logic [31:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.dest_ip = addr;
    endtask

    // one word transfer; push stays high on return so back-to-back words need no gap
    task automatic send_word(input logic [63:0] d, input logic [3:0] nb, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_in_data  <= d;
        i_in_bytes <= nb;
        i_in_last  <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
    endtask

    function automatic void set_frame_byte(int unsigned pos, logic [7:0] v);
        if (pos < frame_bytes.size()) frame_bytes[pos] = v;
    endfunction

    // ethernet frame with an optional vlan tag and an optional ipv4 header start
    function automatic void build_frame(int unsigned len, bit vlan, bit ip,
                                        int unsigned ihl, t_fill fill);
        int unsigned off;
        frame_bytes.delete();
        repeat (len) begin
            case (fill)
                FILL_ONES: frame_bytes.push_back(8'hFF);
                FILL_ZERO: frame_bytes.push_back(8'h00);
                default:   frame_bytes.push_back(8'($urandom));
            endcase
        end
        off = vlan ? idrc_tb_pkg::IP_AT_TAGGED : idrc_tb_pkg::IP_AT_UNTAGGED;
        if (vlan) begin
            set_frame_byte(12, idrc_tb_pkg::TPID_VLAN[15:8]);
            set_frame_byte(13, idrc_tb_pkg::TPID_VLAN[7:0]);
        end
        // the ihl nibble may be anything, including values under five and zero
        if (ip) begin
            set_frame_byte(off - 2, idrc_tb_pkg::TYPE_IPV4[15:8]);
            set_frame_byte(off - 1, idrc_tb_pkg::TYPE_IPV4[7:0]);
            set_frame_byte(off, {4'h4, 4'(ihl)});
        end
    endfunction

    // sends frame_bytes; odd_word gets a random byte count even though it is not
    // the last word, and last_nb below zero picks the natural count for the tail
    task automatic send_frame(input int odd_word, input int last_nb);
        int          len;
        int          nw;
        int          k;
        int          i;
        int          rem;
        logic [63:0] d;
        logic [3:0]  nb;
        len = frame_bytes.size();
        nw  = (len + 7) / 8;
        for (k = 0; k < nw; k++) begin
            // bytes past the frame end carry garbage that the block must clear
            for (i = 0; i < 8; i++)
                d[63 - 8 * i -: 8] = (8 * k + i < len) ? frame_bytes[8 * k + i] : 8'($urandom);
            if (k + 1 < nw) begin
                nb = (k == odd_word) ? 4'($urandom_range(15)) : 4'd8;
            end else begin
                rem = len - 8 * (nw - 1);
                if (last_nb >= 0)
                    nb = 4'(last_nb);
                else if (rem == 8 && $urandom_range(3) == 0)
                    // zero and nine and up all mean a full word
                    nb = $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
                else
                    nb = 4'(rem);
            end
            send_word(d, nb, k + 1 == nw);
        end
    endtask

    // mostly well-formed ipv4 heads with random content, plus truncated headers,
    // other ether types, runts and malformed byte counts
    task automatic send_random_frame();
        int unsigned r;
        int unsigned ihl;
        int unsigned off;
        int unsigned need;
        int unsigned len;
        bit          vlan;
        int          odd;
        t_fill       fill;
        r    = $urandom_range(99);
        vlan = ($urandom_range(3) == 0);
        off  = vlan ? idrc_tb_pkg::IP_AT_TAGGED : idrc_tb_pkg::IP_AT_UNTAGGED;
        ihl  = ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
        odd  = -1;
        fill = ($urandom_range(39) == 0) ? FILL_ONES : FILL_RANDOM;
        need = off + 4 * ihl;
        if (need < idrc_tb_pkg::MIN_BYTES) need = idrc_tb_pkg::MIN_BYTES;
        if (r < 60) begin
            // the odd long frame checks the pass-through path at length
            len = need + (($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(40));
            build_frame(len, vlan, 1'b1, ihl, fill);
        end else if (r < 70) begin
            // frame ends before the ipv4 header does
            ihl = $urandom_range(9, 15);
            len = $urandom_range(idrc_tb_pkg::MIN_BYTES, off + 4 * ihl - 1);
            build_frame(len, vlan, 1'b1, ihl, fill);
        end else if (r < 82) begin
            len = $urandom_range(idrc_tb_pkg::MIN_BYTES, 110);
            build_frame(len, vlan, 1'b0, ihl, fill);
        end else if (r < 92) begin
            // runt, dropped whole
            len = $urandom_range(1, idrc_tb_pkg::MIN_BYTES - 1);
            build_frame(len, vlan, 1'($urandom_range(1)), ihl, fill);
        end else begin
            len = need + $urandom_range(30);
            build_frame(len, vlan, $urandom_range(3) != 0, ihl, fill);
            odd = int'($urandom_range((len + 7) / 8 - 2));
        end
        send_frame(odd, -1);
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_start;
        bit          paused;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_dest(32'hFFFF_FFFF);

        // directed frames
        // single byte runt
        build_frame(1, 1'b0, 1'b0, 0, FILL_ONES);
        send_frame(-1, -1);
        // minimum size ipv4 with ihl zero: nothing summed, address still written
        build_frame(idrc_tb_pkg::MIN_BYTES, 1'b0, 1'b1, 0, FILL_ZERO);
        send_frame(-1, -1);
        // tagged ipv4, ihl fifteen, frame cut off inside the header
        build_frame(50, 1'b1, 1'b1, 15, FILL_ONES);
        send_frame(-1, -1);
        // non-ipv4 with a random count on an inner word and a zero count on the tail
        build_frame(48, 1'b0, 1'b0, 0, FILL_RANDOM);
        send_frame(2, 0);
        // plain ipv4 with an oversized count on a full tail word
        build_frame(48, 1'b0, 1'b1, 5, FILL_RANDOM);
        send_frame(-1, 9);

        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0:       write_dest(32'h0000_0000);
                2:       write_dest(32'h8000_0001);
                default: write_dest($urandom);
            endcase
            send_idle_pct = SEND_IDLE[phase];
            pop_stall_pct = POP_STALL[phase];
            phase_start   = words_sent;
            paused        = 1'b0;
            while (words_sent - phase_start < PHASE_WORDS) begin
                send_random_frame();
                // halfway through, hold the sender until the output side is empty
                if (!paused && words_sent - phase_start >= PHASE_WORDS / 2) begin
                    push <= 1'b0;
                    wait_results();
                    paused = 1'b1;
                end
            end
        end

        settle();
        if (sb.mismatch_count == 0 && sb.expected_words.size() == 0)
            $display("ipv4_dest_rewrite_checksum test passed");
        else
            $display("ipv4_dest_rewrite_checksum test failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("ipv4_dest_rewrite_checksum test failed");
        $finish;
    end

endmodule
